/* sv/timed_switch_command_queue_defines.svh */
// assertion macros used by the timed switch command queue top level
`ifndef TIMED_SWITCH_COMMAND_QUEUE_DEFINES_SVH
`define TIMED_SWITCH_COMMAND_QUEUE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define TSCQ_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// the condition never holds
`define TSCQ_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

/* sv/tscq_pkg.sv */
// types and constants for the timed switch command queue
`timescale 1ns / 1ps
package tscq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TICK_W          = 16;
  localparam int SW_ADDR_W       = 15;
  localparam int ENTRY_W         = SW_ADDR_W + 1;
  localparam int CFG_ADDR_W      = 3;
  localparam int CFG_DATA_W      = 32;

  localparam logic [TICK_W-1:0] ACTIVE_TICKS_RST = 16'd327;
  localparam logic [TICK_W-1:0] DELAY_TICKS_RST  = 16'd50;

  typedef enum logic [1:0] {
    FN_ADD    = 2'd0,
    FN_POLL   = 2'd1,
    FN_RESULT = 2'd2,
    FN_NOP    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_ACTIVE = 2'd1,
    PH_DELAY  = 2'd2,
    PH_WAIT   = 2'd3
  } phase_t;

  typedef enum logic {
    REG_ACTIVE = 1'b0,
    REG_DELAY  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    func_t                 func;
    logic [SW_ADDR_W-1:0]  switch_addr;
    logic                  switch_dir;
    logic                  tx_ready;
    logic                  tx_ok;
    logic [TICK_W-1:0]     now_ticks;
  } item_t;

  typedef struct packed {
    logic                  send_valid;
    logic [SW_ADDR_W-1:0]  send_addr;
    logic                  send_dir;
    logic                  send_on;
    logic                  overflow;
    logic                  all_done;
  } result_t;

endpackage

/* sv/timed_switch_command_queue.sv */
// Timed switch command queue, top level.
// Requests arrive on the in_ channel (valid/stall): func selects add command,
// poll, send result or no-op. Every request yields exactly one result on the out_
// channel, carrying the switch request to issue (send_valid, addr, dir, on),
// the overflow flag of a dropped add and the all_done status.
// A request is taken into an input register, worked combinationally by the
// queue sequencer and lands in the result register, whose valid is out_valid;
// one request is taken per cycle as long as results are taken.
// When out_stall holds a result, the next request
// waits in the input register and in_stall rises only once both are full.
// The hold times sit in apb registers at byte addresses 0 (active) and 4 (delay);
// the user must write them while the queue is quiet, which the block does not enforce.
// Synchronous reset empties the queue, returns the sequencer to idle,
// clears the time mark and loads the hold times with 327 and 50 ticks.
// The command store itself is not cleared; only written entries are read.
`timescale 1ns / 1ps
`include "timed_switch_command_queue_defines.svh"
module timed_switch_command_queue #(
  parameter int QUEUE_DEPTH = tscq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_func,
  input  logic [tscq_pkg::SW_ADDR_W-1:0]   in_switch_addr,
  input  logic                             in_switch_dir,
  input  logic                             in_tx_ready,
  input  logic                             in_tx_ok,
  input  logic [tscq_pkg::TICK_W-1:0]      in_now_ticks,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_send_valid,
  output logic [tscq_pkg::SW_ADDR_W-1:0]   out_send_addr,
  output logic                             out_send_dir,
  output logic                             out_send_on,
  output logic                             out_overflow,
  output logic                             out_all_done,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tscq_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [tscq_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [tscq_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import tscq_pkg::*;

  logic              in_vld_r, in_vld_nxt;
  item_t             item_r;
  logic              out_vld_r, out_vld_nxt;
  result_t           res_r, res;
  logic              advance, in_take;
  logic [TICK_W-1:0] active_ticks, delay_ticks;

  // the held request moves on whenever the result register frees up
  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign in_vld_nxt  = in_take || (in_vld_r && !advance);
  assign out_vld_nxt = advance || (out_vld_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.func        <= func_t'(in_func);
      item_r.switch_addr <= in_switch_addr;
      item_r.switch_dir  <= in_switch_dir;
      item_r.tx_ready    <= in_tx_ready;
      item_r.tx_ok       <= in_tx_ok;
      item_r.now_ticks   <= in_now_ticks;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  tscq_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .active_ticks (active_ticks),
    .delay_ticks  (delay_ticks)
  );

  tscq_core #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .go           (advance),
    .item         (item_r),
    .active_ticks (active_ticks),
    .delay_ticks  (delay_ticks),
    .res          (res)
  );

  assign out_valid      = out_vld_r;
  assign out_send_valid = res_r.send_valid;
  assign out_send_addr  = res_r.send_addr;
  assign out_send_dir   = res_r.send_dir;
  assign out_send_on    = res_r.send_on;
  assign out_overflow   = res_r.overflow;
  assign out_all_done   = res_r.all_done;

  `TSCQ_ASSERT_IMPLIES(a_stall_only_when_full, in_stall, out_vld_r && out_stall && in_vld_r, "input stalled with room downstream")
  `TSCQ_ASSERT_IMPLIES(a_idle_payload_zero, out_vld_r && !res_r.send_valid, res_r.send_addr == '0 && !res_r.send_dir && !res_r.send_on, "send fields set without a send")
  `TSCQ_ASSERT_NEVER(a_send_and_overflow, out_vld_r && res_r.send_valid && res_r.overflow, "send and overflow in one result")
  `TSCQ_ASSERT_NEVER(a_send_and_done, out_vld_r && res_r.send_valid && res_r.all_done, "send reported while all done")

endmodule

/* sv/tscq_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps
module tscq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/tscq_cfg.sv */
// apb register block holding the active and delay hold times
`timescale 1ns / 1ps
module tscq_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tscq_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [tscq_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [tscq_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready,
  output logic [tscq_pkg::TICK_W-1:0]       active_ticks,
  output logic [tscq_pkg::TICK_W-1:0]       delay_ticks
);
  import tscq_pkg::*;

  logic [TICK_W-1:0] active_r, active_nxt;
  logic [TICK_W-1:0] delay_r, delay_nxt;
  reg_idx_t          idx;
  logic              wr_en;

  // registers sit on 4-byte boundaries
  assign idx   = reg_idx_t'(paddr[2]);
  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    active_nxt = active_r;
    delay_nxt  = delay_r;
    if (wr_en) begin
      unique case (idx)
        REG_ACTIVE: active_nxt = pwdata[TICK_W-1:0];
        REG_DELAY:  delay_nxt  = pwdata[TICK_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACTIVE_TICKS_RST;
      delay_r  <= DELAY_TICKS_RST;
    end else begin
      active_r <= active_nxt;
      delay_r  <= delay_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      REG_ACTIVE: prdata = {{(CFG_DATA_W-TICK_W){1'b0}}, active_r};
      REG_DELAY:  prdata = {{(CFG_DATA_W-TICK_W){1'b0}}, delay_r};
    endcase
  end

  assign active_ticks = active_r;
  assign delay_ticks  = delay_r;

endmodule

/* sv/tscq_core.sv */
// ring queue, phase sequencer and hold timer, taking one request per cycle while go is high
`timescale 1ns / 1ps
module tscq_core #(
  parameter int QUEUE_DEPTH = tscq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         go,
  input  tscq_pkg::item_t              item,
  input  logic [tscq_pkg::TICK_W-1:0]  active_ticks,
  input  logic [tscq_pkg::TICK_W-1:0]  delay_ticks,
  output tscq_pkg::result_t            res
);
  import tscq_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(QUEUE_DEPTH - 1);

  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  phase_t            phase_r, phase_nxt;
  phase_t            pend_r, pend_nxt;
  logic [TICK_W-1:0] mark_r, mark_nxt;
  logic              byp_vld_r;
  logic [ENTRY_W-1:0] byp_data_r;

  logic [PTR_W-1:0]   rd_inc, wr_inc;
  logic               empty, full;
  logic [TICK_W-1:0]  elapsed;
  logic               active_done, delay_done;
  logic [ENTRY_W-1:0] ram_rdata, head, wr_data;
  logic               we, retire, send, send_on, ovf, capture;

  assign rd_inc  = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + 1'b1;
  assign wr_inc  = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + 1'b1;
  assign empty   = (rd_ptr_r == wr_ptr_r);
  assign full    = (wr_inc == rd_ptr_r);
  // tick difference wraps with the counter
  assign elapsed     = item.now_ticks - mark_r;
  assign active_done = (elapsed >= active_ticks);
  assign delay_done  = (elapsed >= delay_ticks);
  assign wr_data     = {item.switch_dir, item.switch_addr};

  // phase sequencer: next state
  always_comb begin
    phase_nxt = phase_r;
    pend_nxt  = pend_r;
    if (go) begin
      unique case (item.func)
        FN_POLL: begin
          unique case (phase_r)
            PH_IDLE: begin
              if (!empty && item.tx_ready) begin
                pend_nxt  = PH_ACTIVE;
                phase_nxt = PH_WAIT;
              end
            end
            PH_ACTIVE: begin
              if (active_done && item.tx_ready) begin
                pend_nxt  = PH_DELAY;
                phase_nxt = PH_WAIT;
              end
            end
            PH_DELAY: begin
              if (delay_done) begin
                phase_nxt = PH_IDLE;
              end
            end
            PH_WAIT: ;
          endcase
        end
        FN_RESULT: begin
          if (phase_r == PH_WAIT) begin
            phase_nxt = item.tx_ok ? pend_r : PH_IDLE;
          end
        end
        FN_ADD, FN_NOP: ;
      endcase
    end
  end

  // phase sequencer: outputs
  always_comb begin
    we      = 1'b0;
    ovf     = 1'b0;
    send    = 1'b0;
    send_on = 1'b0;
    retire  = 1'b0;
    capture = 1'b0;
    if (go) begin
      unique case (item.func)
        FN_ADD: begin
          ovf = full;
          we  = !full;
        end
        FN_POLL: begin
          unique case (phase_r)
            PH_IDLE: begin
              send    = !empty && item.tx_ready;
              send_on = send;
            end
            PH_ACTIVE: send   = active_done && item.tx_ready;
            PH_DELAY:  retire = delay_done;
            PH_WAIT: ;
          endcase
        end
        FN_RESULT: capture = (phase_r == PH_WAIT) && item.tx_ok;
        FN_NOP: ;
      endcase
    end
  end

  assign rd_ptr_nxt = retire ? rd_inc : rd_ptr_r;
  assign wr_ptr_nxt = we ? wr_inc : wr_ptr_r;
  assign mark_nxt   = capture ? item.now_ticks : mark_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r  <= '0;
      wr_ptr_r  <= '0;
      phase_r   <= PH_IDLE;
      pend_r    <= PH_IDLE;
      mark_r    <= '0;
      byp_vld_r <= 1'b0;
    end else begin
      rd_ptr_r  <= rd_ptr_nxt;
      wr_ptr_r  <= wr_ptr_nxt;
      phase_r   <= phase_nxt;
      pend_r    <= pend_nxt;
      mark_r    <= mark_nxt;
      byp_vld_r <= we && (wr_ptr_r == rd_ptr_nxt);
    end
  end

  // a write to the entry being fetched is missed by the registered ram read, so it is bypassed
  always_ff @(posedge clk) begin
    byp_data_r <= wr_data;
  end

  tscq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (wr_ptr_r),
    .wdata (wr_data),
    .raddr (rd_ptr_nxt),
    .rdata (ram_rdata)
  );

  assign head = byp_vld_r ? byp_data_r : ram_rdata;

  always_comb begin
    res.send_valid = send;
    res.send_addr  = send ? head[SW_ADDR_W-1:0] : '0;
    res.send_dir   = send && head[SW_ADDR_W];
    res.send_on    = send_on;
    res.overflow   = ovf;
    res.all_done   = (phase_nxt == PH_IDLE) && (rd_ptr_nxt == wr_ptr_nxt);
  end

endmodule

/* tb/sv/tb_top.sv */
// self-checking testbench for the timed switch command queue
`timescale 1ns / 1ps
module tb_top;
  import tscq_pkg::*;

  localparam int LIMIT_CYCLES = 300000;
  localparam int PTR_W = $clog2(QUEUE_DEPTH_DEF);

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  item_t cur_req = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_send_valid;
  logic [SW_ADDR_W-1:0] out_send_addr;
  logic out_send_dir;
  logic out_send_on;
  logic out_overflow;
  logic out_all_done;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  // shadow of the sequencer
  logic [ENTRY_W-1:0] cmd_mem [QUEUE_DEPTH_DEF];
  logic [PTR_W-1:0] rd_ptr = '0;
  logic [PTR_W-1:0] wr_ptr = '0;
  phase_t seq_ph = PH_IDLE;
  phase_t after_ph = PH_IDLE;
  logic [TICK_W-1:0] mark_tick = '0;
  logic [TICK_W-1:0] hold_active = ACTIVE_TICKS_RST;
  logic [TICK_W-1:0] hold_delay = DELAY_TICKS_RST;

  item_t req_fifo [$];
  result_t due_results [$];
  bit in_acc = 1'b0;
  int unsigned cyc = 0;
  int unsigned errors = 0;
  logic [TICK_W-1:0] clock_now = '0;

  timed_switch_command_queue uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (cur_req.func),
    .in_switch_addr (cur_req.switch_addr),
    .in_switch_dir  (cur_req.switch_dir),
    .in_tx_ready    (cur_req.tx_ready),
    .in_tx_ok       (cur_req.tx_ok),
    .in_now_ticks   (cur_req.now_ticks),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_send_valid (out_send_valid),
    .out_send_addr  (out_send_addr),
    .out_send_dir   (out_send_dir),
    .out_send_on    (out_send_on),
    .out_overflow   (out_overflow),
    .out_all_done   (out_all_done),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic bit pct(int p);
    return $urandom_range(0, 99) < p;
  endfunction

  function automatic logic rbit();
    return logic'($urandom_range(0, 1));
  endfunction

  // no idling inside a quiet window
  function automatic bit take_break();
    return !(cyc >= 2000 && cyc < 3500) && pct(28);
  endfunction

  function automatic result_t switch_seq_step(item_t it);
    result_t r;
    logic [PTR_W-1:0] nxt;
    logic [ENTRY_W-1:0] head;
    logic [TICK_W-1:0] gone;
    r = '0;
    head = cmd_mem[rd_ptr];
    gone = it.now_ticks - mark_tick;
    case (it.func)
      FN_ADD: begin
        nxt = wr_ptr + 1'b1;
        if (nxt == rd_ptr) begin
          r.overflow = 1'b1;
        end else begin
          cmd_mem[wr_ptr] = {it.switch_dir, it.switch_addr};
          wr_ptr = nxt;
        end
      end
      FN_POLL: begin
        case (seq_ph)
          PH_IDLE: begin
            if (rd_ptr != wr_ptr && it.tx_ready) begin
              r.send_valid = 1'b1;
              r.send_on = 1'b1;
              after_ph = PH_ACTIVE;
              seq_ph = PH_WAIT;
            end
          end
          PH_ACTIVE: begin
            if (gone >= hold_active && it.tx_ready) begin
              r.send_valid = 1'b1;
              r.send_on = 1'b0;
              after_ph = PH_DELAY;
              seq_ph = PH_WAIT;
            end
          end
          PH_DELAY: begin
            // retiring needs no transmitter
            if (gone >= hold_delay) begin
              rd_ptr = rd_ptr + 1'b1;
              seq_ph = PH_IDLE;
            end
          end
          default: ;
        endcase
        if (r.send_valid) begin
          r.send_addr = head[SW_ADDR_W-1:0];
          r.send_dir = head[SW_ADDR_W];
        end
      end
      FN_RESULT: begin
        if (seq_ph == PH_WAIT) begin
          if (it.tx_ok) begin
            mark_tick = it.now_ticks;
            seq_ph = after_ph;
          end else begin
            seq_ph = PH_IDLE;
          end
        end
      end
      default: ;
    endcase
    r.all_done = (seq_ph == PH_IDLE) && (rd_ptr == wr_ptr);
    return r;
  endfunction

  function automatic item_t mk(func_t f, logic [TICK_W-1:0] t);
    item_t it;
    it.func = f;
    it.switch_addr = SW_ADDR_W'($urandom);
    it.switch_dir = rbit();
    it.tx_ready = rbit();
    it.tx_ok = rbit();
    it.now_ticks = t;
    return it;
  endfunction

  task automatic queue_add(logic [SW_ADDR_W-1:0] a, logic d, logic [TICK_W-1:0] t);
    item_t it;
    it = mk(FN_ADD, t);
    it.switch_addr = a;
    it.switch_dir = d;
    req_fifo.push_back(it);
  endtask

  task automatic queue_op(func_t f, logic rdy, logic ok, logic [TICK_W-1:0] t);
    item_t it;
    it = mk(f, t);
    it.tx_ready = rdy;
    it.tx_ok = ok;
    req_fifo.push_back(it);
  endtask

  // one pass of optional adds, on, hold, off, hold, retire with random faults
  task automatic switch_episode();
    logic [TICK_W-1:0] t;
    logic [TICK_W-1:0] on_mark;
    logic [TICK_W-1:0] off_mark;
    int n_add;
    n_add = 0;
    if (pct(5)) n_add = $urandom_range(2, 17);
    else if (pct(35)) n_add = 1;
    repeat (n_add) queue_add(SW_ADDR_W'($urandom), rbit(), clock_now);
    if (pct(15)) req_fifo.push_back(mk(func_t'($urandom_range(0, 3)),
                                       TICK_W'(clock_now + $urandom_range(0, 9))));
    t = clock_now;
    queue_op(FN_POLL, pct(90), rbit(), t);
    if (pct(10)) queue_op(FN_POLL, 1'b1, rbit(), TICK_W'(t + 1));
    on_mark = TICK_W'(t + $urandom_range(0, 3));
    queue_op(FN_RESULT, rbit(), pct(90), on_mark);
    if (hold_active != 0 && pct(30))
      queue_op(FN_POLL, 1'b1, rbit(), TICK_W'(on_mark + hold_active - 1));
    t = TICK_W'(on_mark + hold_active + $urandom_range(0, 2));
    queue_op(FN_POLL, pct(90), rbit(), t);
    off_mark = TICK_W'(t + $urandom_range(0, 3));
    queue_op(FN_RESULT, rbit(), pct(90), off_mark);
    if (hold_delay != 0 && pct(30))
      queue_op(FN_POLL, rbit(), rbit(), TICK_W'(off_mark + hold_delay - 1));
    t = TICK_W'(off_mark + hold_delay + $urandom_range(0, 2));
    queue_op(FN_POLL, rbit(), rbit(), t);
    clock_now = TICK_W'(t + $urandom_range(0, 50));
  endtask

  task automatic wait_quiet();
    while (req_fifo.size() != 0 || in_valid || due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_hold(reg_idx_t idx, logic [TICK_W-1:0] val);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = {16'h0000, val};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_ACTIVE) hold_active = val;
    else hold_delay = val;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic run_batch(int n);
    @(posedge clk);
    while (req_fifo.size() < n) switch_episode();
    wait_quiet();
  endtask

  // request side: predict on acceptance, result side: check
  always @(posedge clk) begin
    result_t got;
    result_t want;
    in_acc = rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_send_valid, out_send_addr, out_send_dir, out_send_on,
             out_overflow, out_all_done};
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: v=%b a=%h d=%b on=%b ovf=%b done=%b",
                   got.send_valid, got.send_addr, got.send_dir, got.send_on,
                   got.overflow, got.all_done);
      end else begin
        want = due_results.pop_front();
        if (got.send_valid !== want.send_valid || got.send_addr !== want.send_addr ||
            got.send_dir !== want.send_dir || got.send_on !== want.send_on ||
            got.overflow !== want.overflow || got.all_done !== want.all_done) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected v=%b a=%h d=%b on=%b ovf=%b done=%b, got v=%b a=%h d=%b on=%b ovf=%b done=%b",
                     want.send_valid, want.send_addr, want.send_dir, want.send_on,
                     want.overflow, want.all_done, got.send_valid, got.send_addr,
                     got.send_dir, got.send_on, got.overflow, got.all_done);
        end
      end
    end
    if (in_acc) due_results.push_back(switch_seq_step(cur_req));
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_acc) begin
      if (req_fifo.size() != 0 && !take_break()) begin
        cur_req <= req_fifo.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= take_break();
  end

  always @(posedge clk) begin
    cyc++;
    if (cyc >= LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [TICK_W-1:0] act_set [6];
    logic [TICK_W-1:0] dly_set [6];
    act_set = '{16'd0, 16'hFFFF, TICK_W'($urandom), 16'd1, 16'hFFFF, TICK_W'($urandom_range(0, 20))};
    dly_set = '{16'd0, 16'hFFFF, TICK_W'($urandom), 16'hFFFF, 16'd0, TICK_W'($urandom_range(0, 20))};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    // directed walk with the reset hold times
    queue_op(FN_POLL, 1'b1, 1'b0, 16'd0);
    queue_op(FN_RESULT, 1'b1, 1'b1, 16'd1);
    queue_op(FN_NOP, 1'b1, 1'b1, 16'd2);
    queue_add(15'h7FFF, 1'b1, 16'd3);
    queue_add(15'h0000, 1'b0, 16'd4);
    queue_op(FN_POLL, 1'b0, 1'b1, 16'd10);
    queue_op(FN_POLL, 1'b1, 1'b0, 16'd20);
    queue_op(FN_POLL, 1'b1, 1'b1, 16'd21);
    queue_add(15'h2AAA, 1'b1, 16'd22);
    queue_op(FN_RESULT, 1'b1, 1'b0, 16'd25);
    queue_op(FN_POLL, 1'b1, 1'b0, 16'd30);
    queue_op(FN_RESULT, 1'b0, 1'b1, 16'd65500);
    // elapsed wraps past zero
    queue_op(FN_POLL, 1'b1, 1'b0, 16'd290);
    queue_op(FN_POLL, 1'b0, 1'b1, 16'd291);
    queue_op(FN_POLL, 1'b1, 1'b0, 16'd291);
    queue_op(FN_RESULT, 1'b1, 1'b1, 16'hFFFF);
    queue_op(FN_POLL, 1'b1, 1'b0, 16'd48);
    queue_op(FN_POLL, 1'b0, 1'b0, 16'd49);
    queue_op(FN_POLL, 1'b1, 1'b1, 16'd60);
    queue_op(FN_RESULT, 1'b0, 1'b1, 16'd60);
    queue_op(FN_POLL, 1'b1, 1'b0, 16'd387);
    queue_op(FN_RESULT, 1'b0, 1'b1, 16'd387);
    queue_op(FN_POLL, 1'b0, 1'b0, 16'd437);
    clock_now = 16'd500;
    wait_quiet();

    for (int p = 0; p < 6; p++) begin
      write_hold(REG_ACTIVE, act_set[p]);
      write_hold(REG_DELAY, dly_set[p]);
      @(posedge clk);
      // overrun the queue once for sure
      if (p == 0) repeat (17) queue_add(SW_ADDR_W'($urandom), rbit(), clock_now);
      run_batch(120);
      run_batch(120);
    end

    repeat (10) @(posedge clk);
    if (due_results.size() != 0) errors++;
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
